@@ sv/jife_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the value step function of the json integer field extractor
// depends on nothing; used by every module of the block

package jife_pkg;

  // key window size, limited to the eight bytes a 64-bit key register holds
  localparam int KEY_MAX_BYTES = 8;
  localparam int KEY_CELLS     = (KEY_MAX_BYTES < 8) ? KEY_MAX_BYTES : 8;
  localparam int KEY_IDX_W     = (KEY_CELLS > 1) ? $clog2(KEY_CELLS) : 1;
  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int ACC_W         = 32;
  localparam int CFG_IDX_W     = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TEXT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;

  // result status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_UNTERM = 2'd2;

  // characters
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_COLON  = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [ACC_W-1:0]   acc;
    logic               neg;
    logic               first;
  } val_state_t;

  // control for the key match cells
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // state at the start of a message
  localparam val_state_t VAL_IDLE = '{phase: PH_SEARCH, acc: '0, neg: 1'b0, first: 1'b1};
  // state at the first key byte once the key is found
  localparam val_state_t VAL_KEY  = '{phase: PH_COLON, acc: '0, neg: 1'b0, first: 1'b1};

  // effective key length, 1 up to the cell count
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] kl);
    logic [LEN_W-1:0] n;
    n = kl;
    if (n == '0) n = LEN_W'(1);
    if (n > LEN_W'(KEY_CELLS)) n = LEN_W'(KEY_CELLS);
    return n;
  endfunction

  // one byte at or after the key start: colon seek and value accumulation
  function automatic val_state_t value_step(input val_state_t s, input logic [7:0] b);
    val_state_t r;
    r = s;
    case (s.phase)
      PH_COLON: begin
        if (b == CH_COLON) r.phase = PH_VALUE;
      end
      PH_VALUE: begin
        if (b == CH_COMMA || b == CH_RBRACE) begin
          r.phase = PH_DONE;
        end else if (s.first && b == CH_MINUS) begin
          r.neg   = 1'b1;
          r.first = 1'b0;
        end else begin
          r.acc   = (s.acc << 3) + (s.acc << 1) + {{(ACC_W-8){1'b0}}, b}
                    - {{(ACC_W-8){1'b0}}, CH_ZERO};
          r.first = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

@@ sv/jife_match_cell.sv @@
`timescale 1ns / 1ps
// one cell of the key match chain: holds "last bytes equal the key prefix up to here"
// depends on jife_pkg

module jife_match_cell (
  input  logic                clk,
  input  logic                rst,
  input  jife_pkg::cell_ctl_t ctl,
  input  logic                prev_flag,   // neighbor flag, one byte older
  input  logic [7:0]          byte_in,
  input  logic [7:0]          key_byte,
  output logic                hit,         // prefix match including the new byte
  output logic                flag
);

  // extend the neighbor's prefix match by this byte
  assign hit = prev_flag && (byte_in == key_byte);

  // flag register
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      flag <= 1'b0;
    end else if (ctl.shift) begin
      flag <= hit;
    end
  end

endmodule

@@ sv/jife_replay.sv @@
`timescale 1ns / 1ps
// key registers and the replay of the key bytes through the value step after a write
// depends on jife_pkg

module jife_replay (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr,
  input  logic [jife_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [jife_pkg::KEY_W-1:0]         wr_data,
  output logic [jife_pkg::KEY_W-1:0]         key_text,
  output logic [jife_pkg::LEN_W-1:0]         len_eff,
  output jife_pkg::val_state_t               key_state,
  output logic                               busy
);

  logic [jife_pkg::LEN_W-1:0]     key_length;
  logic [jife_pkg::KEY_IDX_W-1:0] step_idx;
  logic [7:0]                     step_byte;
  logic                           step_end;

  assign len_eff   = jife_pkg::eff_len(key_length);
  assign step_byte = key_text[step_idx*8 +: 8];
  assign step_end  = (jife_pkg::LEN_W'(step_idx) == len_eff - jife_pkg::LEN_W'(1));

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_text   <= '0;
      key_length <= jife_pkg::LEN_W'(1);
    end else if (wr) begin
      unique case (wr_index)
        jife_pkg::REG_KEY_TEXT:   key_text   <= wr_data;
        jife_pkg::REG_KEY_LENGTH: key_length <= wr_data[jife_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // one key byte per cycle through the value step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step_idx  <= '0;
      key_state <= jife_pkg::VAL_KEY;
    end else if (wr) begin
      busy      <= 1'b1;
      step_idx  <= '0;
      key_state <= jife_pkg::VAL_KEY;
    end else if (busy) begin
      key_state <= jife_pkg::value_step(key_state, step_byte);
      if (step_end) begin
        busy <= 1'b0;
      end else begin
        step_idx <= step_idx + jife_pkg::KEY_IDX_W'(1);
      end
    end
  end

  // reset config (zero key, length one) leaves the colon seek untouched
  a_reset_state: assert property (@(posedge clk)
    rst |=> !busy && key_state.phase == jife_pkg::PH_COLON && key_state.acc == '0)
    else $error("replay state wrong after reset");

  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    wr |=> busy && step_idx == '0)
    else $error("key write did not restart replay");

  a_no_search: assert property (@(posedge clk) disable iff (rst)
    key_state.phase != jife_pkg::PH_SEARCH)
    else $error("replay state fell back to key search");

endmodule

@@ sv/json_integer_field_extractor.sv @@
`timescale 1ns / 1ps
// top level: takes one json byte per beat, searches the key and extracts its integer value
// depends on jife_pkg, jife_match_cell, jife_replay
// one byte per cycle while s_tready is high; a message result is registered in the output
// register (the skid register while the output is full); config writes hold s_tready low
// while the key bytes (1 to 8) are replayed through the value unit, one per cycle
// two result registers (output plus skid) let input continue while a result waits
// reset (synchronous): key_text 0, key_length 1, message state and results cleared

module json_integer_field_extractor (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] in_byte
  input  logic                           s_tlast,   // in_last
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // [1:0] status, [33:2] int_value
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jife_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jife_pkg::KEY_W-1:0]     cfg_data
);

  logic                            accept;
  logic                            cfg_wr;
  logic [jife_pkg::KEY_W-1:0]      key_text;
  logic [jife_pkg::LEN_W-1:0]      len_eff;
  logic [jife_pkg::LEN_W-1:0]      len_m1;
  jife_pkg::val_state_t            key_state;
  logic                            rp_busy;

  logic                            in_quotes;
  logic [7:0]                      last_kept;
  jife_pkg::val_state_t            vs;
  jife_pkg::val_state_t            vs_next;

  logic                            blank;
  logic                            kept;
  logic                            toggle;
  logic                            key_hit;
  jife_pkg::cell_ctl_t             cell_ctl;
  logic [jife_pkg::KEY_CELLS-1:0]  hit;
  logic [jife_pkg::KEY_CELLS-1:0]  flag;

  logic                            res_new;
  logic [1:0]                      res_status;
  logic [jife_pkg::ACC_W-1:0]      res_acc;
  logic                            out_valid;
  logic [1:0]                      out_status;
  logic [jife_pkg::ACC_W-1:0]      out_acc;
  logic                            out_neg;
  logic                            skid_valid;
  logic [1:0]                      skid_status;
  logic [jife_pkg::ACC_W-1:0]      skid_acc;
  logic                            skid_neg;
  logic                            pop;
  logic [jife_pkg::ACC_W-1:0]      out_value;

  // handshakes
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign s_tready  = !rp_busy && !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign pop       = out_valid && m_tready;

  jife_replay u_replay (
    .clk       (clk),
    .rst       (rst),
    .wr        (cfg_wr),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .key_text  (key_text),
    .len_eff   (len_eff),
    .key_state (key_state),
    .busy      (rp_busy)
  );

  // whitespace drop and quote tracking
  assign blank  = (s_tdata == jife_pkg::CH_SPACE) ||
                  (s_tdata >= jife_pkg::CH_TAB && s_tdata <= jife_pkg::CH_CR);
  assign kept   = !(blank && !in_quotes);
  assign toggle = kept && (last_kept != jife_pkg::CH_BSLASH) && (s_tdata == jife_pkg::CH_QUOTE);

  // key match chain
  assign cell_ctl.shift = accept && kept && (vs.phase == jife_pkg::PH_SEARCH);
  assign cell_ctl.clear = accept && s_tlast;

  for (genvar k = 0; k < jife_pkg::KEY_CELLS; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_first
      assign prev = 1'b1;
    end else begin : g_rest
      assign prev = flag[k-1];
    end
    jife_match_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .prev_flag (prev),
      .byte_in   (s_tdata),
      .key_byte  (key_text[k*8 +: 8]),
      .hit       (hit[k]),
      .flag      (flag[k])
    );
  end

  assign len_m1  = len_eff - jife_pkg::LEN_W'(1);
  assign key_hit = hit[len_m1[jife_pkg::KEY_IDX_W-1:0]];

  // message state update for a kept byte
  always_comb begin
    vs_next = vs;
    if (kept) begin
      if (vs.phase == jife_pkg::PH_SEARCH) begin
        if (key_hit) vs_next = key_state;
      end else begin
        vs_next = jife_pkg::value_step(vs, s_tdata);
      end
    end
  end

  // result of a message end
  always_comb begin
    res_new    = accept && s_tlast;
    res_acc    = '0;
    res_status = jife_pkg::ST_UNTERM;
    if (vs_next.phase == jife_pkg::PH_DONE) begin
      res_status = jife_pkg::ST_FOUND;
      res_acc    = vs_next.acc;
    end else if (vs_next.phase == jife_pkg::PH_SEARCH) begin
      res_status = jife_pkg::ST_ABSENT;
    end
  end

  // message state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes <= 1'b0;
      last_kept <= jife_pkg::CH_SPACE;
      vs        <= jife_pkg::VAL_IDLE;
    end else if (accept) begin
      if (s_tlast) begin
        in_quotes <= 1'b0;
        last_kept <= jife_pkg::CH_SPACE;
        vs        <= jife_pkg::VAL_IDLE;
      end else begin
        in_quotes <= in_quotes ^ toggle;
        if (kept && !toggle) last_kept <= s_tdata;
        vs <= vs_next;
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_status <= skid_status;
        out_acc    <= skid_acc;
        out_neg    <= skid_neg;
        skid_valid <= 1'b0;
      end
    end else if (res_new) begin
      if (!out_valid || pop) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_acc    <= res_acc;
        out_neg    <= vs_next.neg;
      end else begin
        skid_valid  <= 1'b1;
        skid_status <= res_status;
        skid_acc    <= res_acc;
        skid_neg    <= vs_next.neg;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign out_value = out_neg ? (jife_pkg::ACC_W'(0) - out_acc) : out_acc;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'b0, out_value, out_status};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> out_valid)
    else $error("message end produced no result");

  a_message_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (vs.phase == jife_pkg::PH_SEARCH && !in_quotes && flag == '0))
    else $error("message state not cleared after last byte");

  a_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != jife_pkg::ST_FOUND) |-> out_acc == '0)
    else $error("nonzero value on a result without a value");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !s_tready)
    else $error("input accepted during key replay");

endmodule
